// ===== rtl/pfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types, codes and constants of the free page list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  // Default sizing
  localparam int NUM_PAGES_DEF   = 32768;
  localparam int ALIGN_PAGES_DEF = 4;

  // 4 KB pages: byte address = page index << PAGE_SHIFT
  localparam int PAGE_SHIFT = 12;

  // Configuration registers
  localparam int CFG_W      = 28;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [CFG_W-1:0] LOW_ADDR_RST = 28'h000_0000;
  localparam logic [CFG_W-1:0] TOP_ADDR_RST = 28'h800_0000;
  localparam logic REG_LOW_ADDR = 1'b0;
  localparam logic REG_TOP_ADDR = 1'b1;

  // Request kinds
  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_ALIGN = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd1;
  localparam logic [1:0] STATUS_NONE     = 2'd2;

  typedef logic [26:0] res_addr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] page_addr;
  } in_item_t;

  typedef struct packed {
    res_addr_t  result_addr;
    logic [1:0] status;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_UNLINK_WAIT,
    S_FINISH
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_FREE,
    CMD_POP_RD,
    CMD_POP_UPD,
    CMD_SET_NONE,
    CMD_SET_ZERO,
    CMD_WALK_START,
    CMD_STEP_RD,
    CMD_STEP_UPD,
    CMD_UNLINK_RD,
    CMD_UNLINK_UPD
  } cmd_t;

  typedef struct packed {
    cmd_t op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       head_valid;
    logic       cur_valid;
    logic       cur_aligned;
    logic       steps_done;
  } dp_status_t;

  // Number of trailing zero bits of a small positive value (up to 64)
  function automatic int tz_count(input int v);
    int n;
    int done;
    n    = 0;
    done = 0;
    for (int i = 0; i < 7; i++) begin
      if (done == 0 && ((v >> i) & 1) == 0) begin
        n = n + 1;
      end else begin
        done = 1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd value modulo 2**bits, by Newton iteration
  function automatic int odd_inverse(input int a, input int bits);
    int x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (2 - a * x);
    end
    return x & ((1 << bits) - 1);
  endfunction

endpackage

// ===== rtl/pfla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ctrl
// Request sequencer: steps each item through free, pop or aligned walk and
// owns the item handshakes.
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pfla_pkg::dp_status_t status,
  output pfla_pkg::dp_cmd_t    cmd
);

  pfla_pkg::state_t state_r;
  pfla_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;
  logic             walk_end;

  // Output slot can take a result this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign walk_end = !status.cur_valid || status.steps_done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfla_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pfla_pkg::S_EXEC;
      end
      pfla_pkg::S_EXEC: begin
        case (status.kind)
          pfla_pkg::KIND_ALLOC: begin
            state_nxt = status.head_valid ? pfla_pkg::S_POP_WAIT : pfla_pkg::S_FINISH;
          end
          pfla_pkg::KIND_ALIGN: state_nxt = pfla_pkg::S_WALK;
          default:              state_nxt = pfla_pkg::S_FINISH;
        endcase
      end
      pfla_pkg::S_POP_WAIT: state_nxt = pfla_pkg::S_FINISH;
      pfla_pkg::S_WALK: begin
        if (walk_end) begin
          state_nxt = pfla_pkg::S_FINISH;
        end else if (status.cur_aligned) begin
          state_nxt = pfla_pkg::S_UNLINK_WAIT;
        end else begin
          state_nxt = pfla_pkg::S_WALK_WAIT;
        end
      end
      pfla_pkg::S_WALK_WAIT:   state_nxt = pfla_pkg::S_WALK;
      pfla_pkg::S_UNLINK_WAIT: state_nxt = pfla_pkg::S_FINISH;
      pfla_pkg::S_FINISH: begin
        if (out_free) state_nxt = in_valid ? pfla_pkg::S_EXEC : pfla_pkg::S_IDLE;
      end
      default: state_nxt = pfla_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and input stall
  always_comb begin
    cmd.op       = pfla_pkg::CMD_NONE;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    unique case (state_r)
      pfla_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = pfla_pkg::CMD_CAPTURE;
      end
      pfla_pkg::S_EXEC: begin
        case (status.kind)
          pfla_pkg::KIND_FREE:  cmd.op = pfla_pkg::CMD_FREE;
          pfla_pkg::KIND_ALLOC: begin
            cmd.op = status.head_valid ? pfla_pkg::CMD_POP_RD : pfla_pkg::CMD_SET_NONE;
          end
          pfla_pkg::KIND_ALIGN: cmd.op = pfla_pkg::CMD_WALK_START;
          default:              cmd.op = pfla_pkg::CMD_SET_ZERO;
        endcase
      end
      pfla_pkg::S_POP_WAIT: cmd.op = pfla_pkg::CMD_POP_UPD;
      pfla_pkg::S_WALK: begin
        if (walk_end) begin
          cmd.op = pfla_pkg::CMD_SET_NONE;
        end else if (status.cur_aligned) begin
          cmd.op = pfla_pkg::CMD_UNLINK_RD;
        end else begin
          cmd.op = pfla_pkg::CMD_STEP_RD;
        end
      end
      pfla_pkg::S_WALK_WAIT:   cmd.op = pfla_pkg::CMD_STEP_UPD;
      pfla_pkg::S_UNLINK_WAIT: cmd.op = pfla_pkg::CMD_UNLINK_UPD;
      pfla_pkg::S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_stall     = 1'b0;
          if (in_valid) cmd.op = pfla_pkg::CMD_CAPTURE;
        end
      end
      default: begin
        cmd.op = pfla_pkg::CMD_NONE;
      end
    endcase
  end

  // Hold a result until the far side takes it
  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/pfla_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_dpath
// List head, next-page table, walk registers, free checks and the result
// registers of the free page list allocator.
// ----------------------------------------------------------------------------
module pfla_dpath #(
  parameter int NUM_PAGES   = pfla_pkg::NUM_PAGES_DEF,
  parameter int ALIGN_PAGES = pfla_pkg::ALIGN_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pfla_pkg::dp_cmd_t              cmd,
  output pfla_pkg::dp_status_t           status,
  input  pfla_pkg::in_item_t             in_data,
  input  logic [pfla_pkg::CFG_W-1:0]     low_addr,
  input  logic [pfla_pkg::CFG_W-1:0]     top_addr,
  output pfla_pkg::out_item_t            out_data
);

  localparam int IDX_W  = $clog2(NUM_PAGES);
  localparam int STEP_W = $clog2(NUM_PAGES + 1);
  localparam int PS     = pfla_pkg::PAGE_SHIFT;

  // Alignment test constants: ALIGN_PAGES = ODD << TZ
  localparam int TZ  = pfla_pkg::tz_count(ALIGN_PAGES);
  localparam int ODD = ALIGN_PAGES >> TZ;
  localparam logic [IDX_W-1:0] INV_K  = IDX_W'(pfla_pkg::odd_inverse(ODD, IDX_W));
  localparam logic [IDX_W-1:0] LIM_K  = IDX_W'(((1 << IDX_W) - 1) / ODD);
  localparam logic [IDX_W-1:0] MASK_K = IDX_W'((1 << TZ) - 1);

  // Link: top bit marks end of list, low bits hold a page index
  typedef logic [IDX_W:0] link_t;
  localparam link_t EMPTY_LINK = {1'b1, {IDX_W{1'b0}}};

  pfla_pkg::in_item_t  req_r, req_nxt;
  link_t               head_r, head_nxt;
  link_t               cur_r, cur_nxt;
  link_t               prev_r, prev_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  pfla_pkg::out_item_t res_r, res_nxt;
  pfla_pkg::out_item_t out_r, out_nxt;
  link_t               rdata_r;

  link_t               next_mem [NUM_PAGES];
  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_addr;
  link_t               mem_wdata;

  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    head_idx;
  logic [IDX_W-1:0]    cur_idx;
  logic [IDX_W-1:0]    prev_idx;
  logic                free_bad;
  logic [IDX_W-1:0]    cur_sh;
  logic [2*IDX_W-1:0]  cur_prod;

  assign free_idx = req_r.page_addr[PS +: IDX_W];
  assign head_idx = head_r[IDX_W-1:0];
  assign cur_idx  = cur_r[IDX_W-1:0];
  assign prev_idx = prev_r[IDX_W-1:0];

  // Reject a free that is misaligned or outside the usable range
  assign free_bad = (req_r.page_addr[PS-1:0] != '0) ||
                    (req_r.page_addr < 32'(low_addr)) ||
                    (req_r.page_addr >= 32'(top_addr)) ||
                    ((req_r.page_addr >> PS) >= 32'(NUM_PAGES));

  // Divisibility by ALIGN_PAGES: low bits clear and odd part by inverse
  assign cur_sh   = cur_idx >> TZ;
  assign cur_prod = cur_sh * INV_K;

  assign status.kind        = req_r.kind;
  assign status.head_valid  = !head_r[IDX_W];
  assign status.cur_valid   = !cur_r[IDX_W];
  assign status.cur_aligned = ((cur_idx & MASK_K) == '0) && (cur_prod[IDX_W-1:0] <= LIM_K);
  assign status.steps_done  = (steps_r == STEP_W'(NUM_PAGES));

  // Table port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cur_idx;
    mem_wdata = head_r;
    case (cmd.op)
      pfla_pkg::CMD_FREE: begin
        mem_we    = !free_bad;
        mem_addr  = free_idx;
        mem_wdata = head_r;
      end
      pfla_pkg::CMD_POP_RD: begin
        mem_re   = 1'b1;
        mem_addr = head_idx;
      end
      pfla_pkg::CMD_STEP_RD, pfla_pkg::CMD_UNLINK_RD: begin
        mem_re   = 1'b1;
        mem_addr = cur_idx;
      end
      pfla_pkg::CMD_UNLINK_UPD: begin
        mem_we    = !prev_r[IDX_W];
        mem_addr  = prev_idx;
        mem_wdata = rdata_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Register updates
  always_comb begin
    req_nxt   = req_r;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    steps_nxt = steps_r;
    res_nxt   = res_r;
    case (cmd.op)
      pfla_pkg::CMD_CAPTURE: req_nxt = in_data;
      pfla_pkg::CMD_FREE: begin
        if (!free_bad) head_nxt = {1'b0, free_idx};
        res_nxt.result_addr = '0;
        res_nxt.status      = free_bad ? pfla_pkg::STATUS_BAD_FREE : pfla_pkg::STATUS_OK;
      end
      pfla_pkg::CMD_POP_RD: begin
        res_nxt.result_addr = pfla_pkg::res_addr_t'({head_idx, {PS{1'b0}}});
        res_nxt.status      = pfla_pkg::STATUS_OK;
      end
      pfla_pkg::CMD_POP_UPD: head_nxt = rdata_r;
      pfla_pkg::CMD_SET_NONE: begin
        res_nxt.result_addr = '0;
        res_nxt.status      = pfla_pkg::STATUS_NONE;
      end
      pfla_pkg::CMD_SET_ZERO: begin
        res_nxt.result_addr = '0;
        res_nxt.status      = pfla_pkg::STATUS_OK;
      end
      pfla_pkg::CMD_WALK_START: begin
        cur_nxt   = head_r;
        prev_nxt  = EMPTY_LINK;
        steps_nxt = '0;
      end
      pfla_pkg::CMD_STEP_RD: begin
        prev_nxt  = cur_r;
        steps_nxt = steps_r + 1'b1;
      end
      pfla_pkg::CMD_STEP_UPD: cur_nxt = rdata_r;
      pfla_pkg::CMD_UNLINK_RD: begin
        res_nxt.result_addr = pfla_pkg::res_addr_t'({cur_idx, {PS{1'b0}}});
        res_nxt.status      = pfla_pkg::STATUS_OK;
      end
      pfla_pkg::CMD_UNLINK_UPD: begin
        if (prev_r[IDX_W]) head_nxt = rdata_r;
      end
      default: begin
        req_nxt = req_r;
      end
    endcase
  end

  // Advance the output register when the controller loads it
  assign out_nxt  = cmd.load_out ? res_r : out_r;
  assign out_data = out_r;

  // List head: empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= EMPTY_LINK;
    end else begin
      head_r <= head_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Next-page table: one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= next_mem[mem_addr];
    end
  end

endmodule

// ===== rtl/page_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// LIFO free list of 4 KB pages with free, allocate and aligned allocate.
// ----------------------------------------------------------------------------
// Each request item gives exactly one result item. The block works on one
// item at a time; its steps follow the single-port next-page table, whose
// read data is registered, and a full output stalls it. A free, an unused
// kind or an allocation from an empty list passes through the execute
// state only; any other allocation adds a wait for the table read of the
// head's link. An aligned allocation reads one link for each unaligned
// page it skips, walking at most NUM_PAGES links, and on a hit reads the
// hit page's link to unlink it. The output register lets a finished result
// wait while the next item is taken. Write low_addr and top_addr only while
// the block is idle. A free that is misaligned, below low_addr, at or above
// top_addr or beyond the table is refused with status 1; an allocation with
// no suitable page returns status 2. Double frees are not detected.
module page_free_list_allocator_top #(
  parameter int NUM_PAGES   = pfla_pkg::NUM_PAGES_DEF,
  parameter int ALIGN_PAGES = pfla_pkg::ALIGN_PAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pfla_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pfla_pkg::out_item_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfla_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pfla_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pfla_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [pfla_pkg::CFG_W-1:0] low_addr_r, low_addr_nxt;
  logic [pfla_pkg::CFG_W-1:0] top_addr_r, top_addr_nxt;
  logic                       cfg_wr;
  pfla_pkg::dp_cmd_t          dp_cmd;
  pfla_pkg::dp_status_t       dp_status;

  // Configuration registers, one word each
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    low_addr_nxt = low_addr_r;
    top_addr_nxt = top_addr_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        pfla_pkg::REG_LOW_ADDR: low_addr_nxt = pwdata[pfla_pkg::CFG_W-1:0];
        pfla_pkg::REG_TOP_ADDR: top_addr_nxt = pwdata[pfla_pkg::CFG_W-1:0];
        default:                low_addr_nxt = low_addr_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pfla_pkg::REG_LOW_ADDR: prdata = pfla_pkg::APB_DATA_W'(low_addr_r);
      pfla_pkg::REG_TOP_ADDR: prdata = pfla_pkg::APB_DATA_W'(top_addr_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_addr_r <= pfla_pkg::LOW_ADDR_RST;
      top_addr_r <= pfla_pkg::TOP_ADDR_RST;
    end else begin
      low_addr_r <= low_addr_nxt;
      top_addr_r <= top_addr_nxt;
    end
  end

  pfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  pfla_dpath #(
    .NUM_PAGES   (NUM_PAGES),
    .ALIGN_PAGES (ALIGN_PAGES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .status   (dp_status),
    .in_data  (in_data),
    .low_addr (low_addr_r),
    .top_addr (top_addr_r),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  // One item in flight: an accepted item blocks the input on the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in work");

  // A result is loaded only into a free output slot
  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a held result");

  // A walk step uses the table read issued in the cycle before
  a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == pfla_pkg::CMD_STEP_UPD) |-> ($past(dp_cmd.op) == pfla_pkg::CMD_STEP_RD))
    else $error("walk step without a preceding table read");
`endif

endmodule
